### rtl/core/scs_pkg.sv
// ============================================================================
// scs_pkg - stick calibration sequencer package
// Shared types, phase codes, register indexes and Q2.14 constants.
// ============================================================================
package scs_pkg;

  // number of stick values carried by one input transaction
  localparam int StickInputs = 4;

  // stream widths; the data widths are whole bytes
  localparam int InDataW  = 96;
  localparam int InUserW  = 2;
  localparam int OutDataW = 56;
  localparam int OutUserW = 2;

  // config port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgShortTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongTimeout  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPassThresh   = 2'd2;

  // register reset values
  localparam logic [15:0] DefShortMs = 16'd5000;
  localparam logic [15:0] DefLongMs  = 16'd20000;
  localparam logic [14:0] DefThresh  = 15'd13107;

  // Q2.14 unity
  localparam logic signed [15:0] QOne    = 16'sd16384;
  localparam logic signed [15:0] QNegOne = -16'sd16384;
  localparam logic signed [15:0] QZero   = 16'sd0;

  typedef enum logic [2:0] {
    PhIdle      = 3'd0,
    PhStart     = 3'd1,
    PhCapture   = 3'd2,
    PhWait      = 3'd3,
    PhConfirmed = 3'd4,
    PhTimeout   = 3'd5,
    PhSuccess   = 3'd6,
    PhFailed    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    LopHold,
    LopStart,
    LopCapture,
    LopWait,
    LopRestore
  } lane_op_e;

  // control sent to every lane
  typedef struct packed {
    logic        en;
    lane_op_e    op;
    logic [14:0] thr;
  } lane_ctrl_t;

  // calibration record of one role
  typedef struct packed {
    logic [15:0] cal_max;
    logic [15:0] cal_center;
    logic [15:0] cal_min;
  } lane_rec_t;

  // per-item status shared by all results of the item
  typedef struct packed {
    logic       save;
    logic       gest;
    logic [2:0] phase;
  } item_meta_t;

endpackage

### rtl/core/stick_calibration_sequencer_core.sv
// ============================================================================
// stick_calibration_sequencer_core - stick calibration wizard
// Phase sequencer driving one lane per stick role, an AND merge of the lane
// pass flags, and a serializer that reports one result per reported role.
// ============================================================================
//
//  channel   dir   handshake                 payload
//  s_axis    in    s_axis_tvalid/tready      tdata: samples, tuser: command
//  m_axis    out   m_axis_tvalid/tready      tdata: calibration, tuser: role,
//                                            tlast: final role of the item
//  cfg       in    cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// order: an accepted item updates all lanes together; its results start
//   the next cycle, one per cycle while m_axis_tready_i is high, one
//   per reported role (min(ROLE_COUNT, 4)), from the serializer's single port
// a new item is taken in the cycle the last result of the previous one leaves
// reset: asynchronous, restores phase idle and the -1/0/+1 scale on all roles
// stalls: a stalled output holds the snapshot and holds s_axis_tready low
//
module stick_calibration_sequencer_core
  import scs_pkg::*;
#(
  parameter int ROLE_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] now_ms, [47:32] stick_a, [63:48] stick_b, [79:64] stick_c,
  // [95:80] stick_d
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] cmd, [1] long_sel
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [15:0] out_min, [31:16] out_center, [47:32] out_max, [50:48] phase,
  // [51] gestures_off, [52] save_request, [55:53] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // [1:0] role
  output logic [OutUserW-1:0] m_axis_tuser_o,
  output logic                m_axis_tlast_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // reported roles
  localparam int NRES = (ROLE_COUNT < StickInputs) ? ROLE_COUNT : StickInputs;

  // ---------------------------------------------------------------- config
  logic [15:0] short_ms_q, long_ms_q;
  logic [14:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_ms_q <= DefShortMs;
      long_ms_q  <= DefLongMs;
      thresh_q   <= DefThresh;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgShortTimeout: short_ms_q <= cfg_wdata_i;
        CfgLongTimeout:  long_ms_q  <= cfg_wdata_i;
        CfgPassThresh:   thresh_q   <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  logic        s_accept;
  logic        cmd_start, long_sel;
  logic [31:0] now_ms;

  assign s_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_start = s_axis_tuser_i[0];
  assign long_sel  = s_axis_tuser_i[1];
  assign now_ms    = s_axis_tdata_i[31:0];

  // ---------------------------------------------------------------- sequencer state
  phase_e      phase_q, phase_d;
  logic [31:0] start_ms_q, start_ms_d;
  logic [15:0] timeout_q, timeout_d;
  logic        gest_q, gest_d;
  logic        save_w;
  lane_op_e    lane_op;
  logic        timed_out;
  logic        pass_all;
  logic [31:0] elapsed;

  // wrapping elapsed time against the active timeout
  assign elapsed   = now_ms - start_ms_q;
  assign timed_out = elapsed > {16'd0, timeout_q};

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (cmd_start) begin
      phase_d = PhStart;
    end else begin
      case (phase_q)
        PhStart:     phase_d = PhCapture;
        PhCapture:   if (timed_out) phase_d = PhWait;
        PhWait: begin
          // timeout wins over a pass in the same tick
          if (timed_out) phase_d = PhTimeout;
          else if (pass_all) phase_d = PhConfirmed;
        end
        PhConfirmed: phase_d = PhSuccess;
        PhTimeout:   phase_d = PhFailed;
        default: ;
      endcase
    end
  end

  // per-phase actions
  always_comb begin
    lane_op    = LopHold;
    save_w     = 1'b0;
    gest_d     = gest_q;
    start_ms_d = start_ms_q;
    timeout_d  = timeout_q;
    if (cmd_start) begin
      // start only arms; the item reports current calibration
      timeout_d = long_sel ? long_ms_q : short_ms_q;
    end else begin
      case (phase_q)
        PhStart: begin
          lane_op    = LopStart;
          start_ms_d = now_ms;
          gest_d     = 1'b1;
        end
        PhCapture: begin
          lane_op = LopCapture;
          if (timed_out) start_ms_d = now_ms;
        end
        PhWait: begin
          lane_op = LopWait;
          if (timed_out) start_ms_d = now_ms;
        end
        PhConfirmed: begin
          save_w = 1'b1;
          gest_d = 1'b0;
        end
        PhTimeout: begin
          lane_op = LopRestore;
          gest_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      start_ms_q <= '0;
      timeout_q  <= DefShortMs;
      gest_q     <= 1'b0;
    end else if (s_accept) begin
      phase_q    <= phase_d;
      start_ms_q <= start_ms_d;
      timeout_q  <= timeout_d;
      gest_q     <= gest_d;
    end
  end

  // ---------------------------------------------------------------- lanes
  lane_ctrl_t              lane_ctrl;
  lane_rec_t               rec_w [ROLE_COUNT];
  lane_rec_t               rep_w [NRES];
  logic [ROLE_COUNT-1:0]   pass_w;

  assign lane_ctrl.en  = s_accept;
  assign lane_ctrl.op  = lane_op;
  assign lane_ctrl.thr = thresh_q;

  for (genvar g = 0; g < ROLE_COUNT; g++) begin : g_lane
    logic signed [15:0] value;
    if (g < StickInputs) begin : g_stick
      assign value = $signed(s_axis_tdata_i[32 + 16*g +: 16]);
    end else begin : g_zero
      // roles beyond the carried sticks read zero and never pass
      assign value = QZero;
    end
    scs_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .value_i (value),
      .rec_o   (rec_w[g]),
      .pass_o  (pass_w[g])
    );
  end

  for (genvar r = 0; r < NRES; r++) begin : g_rep
    assign rep_w[r] = rec_w[r];
  end

  // merge: every role must pass both ways
  assign pass_all = &pass_w;

  // ---------------------------------------------------------------- output
  item_meta_t meta;

  assign meta.save  = save_w;
  assign meta.gest  = gest_d;
  assign meta.phase = phase_d;

  scs_serializer #(
    .NRES (NRES)
  ) u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s_accept),
    .recs_i     (rep_w),
    .meta_i     (meta),
    .ready_o    (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

  // ---------------------------------------------------------------- assertions
  // save request only ever accompanies the success phase
  a_save_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[52]) |-> (m_axis_tdata_o[50:48] == PhSuccess))
    else $error("save request outside success phase");

  // a start command always lands in the start phase
  a_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cmd_start) |=> (phase_q == PhStart))
    else $error("start command did not arm the wizard");

  // capture, wait, confirmed and timeout only run with gestures locked
  a_lock_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhCapture || phase_q == PhWait || phase_q == PhConfirmed ||
     phase_q == PhTimeout) |-> gest_q)
    else $error("wizard running with gestures unlocked");

  // an empty output side always takes input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with no pending results");

endmodule

### rtl/core/scs_lane.sv
// ============================================================================
// scs_lane - per-role calibration lane
// Holds min/centre/max and the test extremes of one stick role.
// ============================================================================
module scs_lane
  import scs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  logic signed [15:0] value_i,
  output lane_rec_t         rec_o,
  output logic              pass_o
);

  logic signed [15:0] min_q, min_d;
  logic signed [15:0] ctr_q, ctr_d;
  logic signed [15:0] max_q, max_d;
  logic signed [15:0] high_q, high_d;
  logic signed [15:0] low_q, low_d;
  logic signed [15:0] thr_pos, thr_neg;

  always_comb begin
    min_d  = min_q;
    ctr_d  = ctr_q;
    max_d  = max_q;
    high_d = high_q;
    low_d  = low_q;
    case (ctrl_i.op)
      LopStart: begin
        min_d  = QOne;
        ctr_d  = value_i;
        max_d  = QNegOne;
        high_d = QNegOne;
        low_d  = QOne;
      end
      LopCapture: begin
        if (value_i > max_q) max_d = value_i;
        if (value_i < min_q) min_d = value_i;
      end
      LopWait: begin
        if (value_i > high_q) high_d = value_i;
        if (value_i < low_q) low_d = value_i;
      end
      LopRestore: begin
        min_d = QNegOne;
        ctr_d = QZero;
        max_d = QOne;
      end
      default: ;
    endcase
  end

  // threshold fits in 15 bits, so both signs fit in 16
  assign thr_pos = $signed({1'b0, ctrl_i.thr});
  assign thr_neg = QZero - thr_pos;
  assign pass_o  = (high_d > thr_pos) && (low_d < thr_neg);

  assign rec_o.cal_min    = min_d;
  assign rec_o.cal_center = ctr_d;
  assign rec_o.cal_max    = max_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= QNegOne;
      ctr_q  <= QZero;
      max_q  <= QOne;
      high_q <= QNegOne;
      low_q  <= QOne;
    end else if (ctrl_i.en) begin
      min_q  <= min_d;
      ctr_q  <= ctr_d;
      max_q  <= max_d;
      high_q <= high_d;
      low_q  <= low_d;
    end
  end

endmodule

### rtl/core/scs_serializer.sv
// ============================================================================
// scs_serializer - result snapshot and role serializer
// Captures the post-item calibration of all reported roles and sends one
// role result per transaction.
// ============================================================================
module scs_serializer
  import scs_pkg::*;
#(
  parameter int NRES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lane_rec_t           recs_i [NRES],
  input  item_meta_t          meta_i,
  output logic                ready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic [OutUserW-1:0] m_tuser_o,
  output logic                m_tlast_o
);

  localparam int IdxW = (NRES > 1) ? $clog2(NRES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NRES - 1);

  lane_rec_t       recs_q [NRES];
  item_meta_t      meta_q;
  logic            valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            is_last, take;
  lane_rec_t       cur;

  assign is_last = (idx_q == LastIdx);
  assign take    = valid_q && m_tready_i;
  assign ready_o = !valid_q || (m_tready_i && is_last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take) begin
      if (is_last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // snapshot payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      recs_q <= recs_i;
      meta_q <= meta_i;
    end
  end

  assign cur        = recs_q[idx_q];
  assign m_tvalid_o = valid_q;
  assign m_tlast_o  = is_last;
  assign m_tuser_o  = OutUserW'(idx_q);
  assign m_tdata_o  = {3'b000, meta_q.save, meta_q.gest, meta_q.phase,
                       cur.cal_max, cur.cal_center, cur.cal_min};

endmodule
